/* src/fant_pkg.sv */
// ----------------------------------------------------------------------------
// fant_pkg: shared constants of the line resampler
// Register indexes and fixed-point constants.
// ----------------------------------------------------------------------------
package fant_pkg;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 21;

  localparam logic [CfgIdxW-1:0] REG_SIZE_FACTOR = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_INV_FACTOR  = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_OUT_LIMIT   = 2'd2;

  // fraction bits of every Q16 quantity (segments, scale, start position)
  localparam int unsigned FRAC_BITS = 16;

  localparam int unsigned PixW   = 8;
  localparam int unsigned IdxW   = 13;
  localparam int unsigned StartW = 29;

endpackage

/* src/fant_line_resampler.sv */
// ----------------------------------------------------------------------------
// fant_line_resampler: Fant area-weighted line resampler
// Sequencer around one shared multiplier that resamples a pixel line.
// ----------------------------------------------------------------------------
// Usage:
//  Input channel in_valid_i / in_stall_o carries one pixel beat with its
//  first/last-of-line flags and, on the first pixel, a signed Q13.16 start.
//  Output channel out_valid_o / out_stall_i carries resampled pixels with
//  their index; line_done_o marks the flushed last pixel of a line.
//  Each pixel is held back one beat and blended with its successor, so the
//  results of a pixel appear while its successor is worked on.
//  A sequencer drives one shared multiplier. A beat passes the accept and
//  pick steps, each area step the loop test, blend, area and accumulate
//  steps, and each output pixel the scale high, scale low and emit steps.
//  A line start adds a start step, or a negate and a split step for a
//  negative start. A last pixel adds a last step, its own area steps and
//  the flush. A skipped pixel passes only the accept and pick steps.
//  The block takes no beat while it works on one.
//  A result waits in the output register when the receiver stalls; the
//  sequencer holds in its emit step until that register is free.
//  Reset returns registers to their defaults (scale one, limit 4095) and
//  clears the line state. Configuration is to be written only when idle;
//  the user is bound to this, as the block itself does not enforce it.
// ----------------------------------------------------------------------------
module fant_line_resampler #(
  parameter int unsigned MAX_LINE  = 4096
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [fant_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [fant_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [7:0]                    pixel_in_i,
  input  logic signed [28:0]            start_position_i,
  input  logic                          first_of_line_i,
  input  logic                          last_of_line_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [7:0]                    pixel_out_o,
  output logic [12:0]                   out_index_o,
  output logic                          line_done_o
);
  import fant_pkg::*;

  localparam int unsigned QW   = FRAC_BITS + 1;     // segment width
  localparam int unsigned OSW  = FRAC_BITS + 5;     // output segment
  localparam int unsigned ACW  = FRAC_BITS + 12;    // accumulator
  localparam int unsigned PVW  = FRAC_BITS + 9;     // pixel value
  localparam int unsigned MW   = 64;                // product width
  localparam logic [QW-1:0]  ONE     = QW'(1) << FRAC_BITS;
  localparam logic [OSW-1:0] INV_MIN = OSW'(1) << (FRAC_BITS - 4);
  localparam logic [OSW-1:0] INV_MAX = OSW'(1) << (FRAC_BITS + 4);
  localparam logic [ACW-1:0] ACC_MAX = {ACW{1'b1}};
  localparam logic [13:0]    LIM_MAX = (MAX_LINE > 8191) ? 14'd8191 : 14'(MAX_LINE);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_START = 4'd1;
  localparam logic [3:0] S_NEG   = 4'd2;
  localparam logic [3:0] S_PICK  = 4'd3;
  localparam logic [3:0] S_LOOP  = 4'd4;
  localparam logic [3:0] S_PV    = 4'd5;
  localparam logic [3:0] S_AREA  = 4'd6;
  localparam logic [3:0] S_SC_HI = 4'd7;
  localparam logic [3:0] S_SC_LO = 4'd8;
  localparam logic [3:0] S_EMIT  = 4'd9;
  localparam logic [3:0] S_LAST  = 4'd10;
  localparam logic [3:0] S_FLUSH = 4'd11;
  localparam logic [3:0] S_NEG2  = 4'd12;
  localparam logic [3:0] S_ACC   = 4'd13;

  logic [3:0] state_q, state_d;

  // configuration
  logic [20:0] size_q, inv_q;
  logic [12:0] limit_q;

  // line state
  logic [7:0]     held_q;
  logic           held_v_q;
  logic [QW-1:0]  iseg_q;
  logic [OSW-1:0] oseg_q;
  logic [ACW-1:0] acc_q;
  logic [12:0]    opos_q;
  logic [12:0]    skip_q;

  // beat capture and work registers
  logic [7:0]         pix_q;
  logic [28:0]        start_q;
  logic               last_q;
  logic               cur_last_q;   // processing the lone last pixel
  logic               flush_q;      // emit is the flush
  logic [PVW-1:0]     pv_q;
  logic [MW-1:0]      prod_q;
  logic [MW-1:0]      scale_q;
  logic               seg_over_done_q;

  // output register
  logic       ov_q;
  logic [7:0] opix_q;
  logic [12:0] oidx_q;
  logic       odone_q;

  // effective values
  logic [OSW-1:0] inv_eff;
  logic [13:0]    lim_eff;
  always_comb begin
    inv_eff = OSW'(inv_q);
    if (inv_eff < INV_MIN) inv_eff = INV_MIN;
    if (inv_eff > INV_MAX) inv_eff = INV_MAX;
    lim_eff = (14'(limit_q) > LIM_MAX) ? LIM_MAX : 14'(limit_q);
  end

  // shared multiplier
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  assign mul_p = 64'(mul_a) * 64'(mul_b);

  logic [28:0] start_mag;
  assign start_mag = 29'd0 - start_q;

  logic           seg_over;
  logic [OSW-1:0] area_seg;
  assign seg_over = oseg_q > OSW'(iseg_q);
  assign area_seg = seg_over ? OSW'(iseg_q) : oseg_q;

  logic [63:0] area_sum;
  logic [63:0] acc_sum;
  assign area_sum = (prod_q + (64'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
  assign acc_sum  = 64'(acc_q) + area_sum;

  logic [63:0] sc_val;
  assign sc_val = (scale_q + (64'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;

  logic [63:0] off;
  assign off = prod_q >> FRAC_BITS;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_START: begin
        mul_a = 32'(inv_eff);
        mul_b = 32'(ONE - QW'(start_q[FRAC_BITS-1:0]));
      end
      S_NEG: begin
        mul_a = 32'(start_mag);
        mul_b = 32'(inv_eff);
      end
      S_PV: begin
        mul_a = 32'(held_q);
        mul_b = 32'(iseg_q);
      end
      S_AREA: begin
        mul_a = 32'(pv_q);
        mul_b = 32'(area_seg);
      end
      S_SC_HI: begin
        mul_a = 32'(acc_q);
        mul_b = 32'(size_q[20:FRAC_BITS]);
      end
      S_SC_LO: begin
        mul_a = 32'(acc_q);
        mul_b = 32'(size_q[FRAC_BITS-1:0]);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // neighbour term of the blend (next pixel over the rest of the segment)
  logic [PVW-1:0] nxt_term;
  assign nxt_term = cur_last_q ? '0 : PVW'(pix_q) * PVW'(ONE - iseg_q);

  assign in_stall_o = state_q != S_IDLE;
  logic in_acc;
  assign in_acc = in_valid_i && !in_stall_o;

  // load the output register when it is free or drains this cycle
  logic emit_go;
  assign emit_go = (state_q == S_EMIT) && (!ov_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q  <= 21'd65536;
      inv_q   <= 21'd65536;
      limit_q <= 13'd4095;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_SIZE_FACTOR: size_q  <= cfg_data_i;
        REG_INV_FACTOR:  inv_q   <= cfg_data_i;
        REG_OUT_LIMIT:   limit_q <= cfg_data_i[12:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      pix_q   <= pixel_in_i;
      start_q <= start_position_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ov_q <= 1'b0;
    else if (emit_go) ov_q <= 1'b1;
    else if (!out_stall_i) ov_q <= 1'b0;
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      held_q     <= '0;
      held_v_q   <= 1'b0;
      iseg_q     <= ONE;
      oseg_q     <= '0;
      acc_q      <= '0;
      opos_q     <= '0;
      skip_q     <= '0;
      last_q     <= 1'b0;
      cur_last_q <= 1'b0;
      flush_q    <= 1'b0;
      pv_q       <= '0;
      prod_q     <= '0;
      scale_q    <= '0;
      opix_q     <= '0;
      oidx_q     <= '0;
      odone_q    <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            last_q     <= last_of_line_i;
            cur_last_q <= 1'b0;
            if (first_of_line_i) begin
              held_q   <= '0;
              held_v_q <= 1'b0;
              acc_q    <= '0;
              skip_q   <= '0;
              state_q  <= start_position_i[28] ? S_NEG : S_START;
            end else begin
              state_q <= S_PICK;
            end
          end
        end
        S_START: begin
          opos_q  <= start_q[FRAC_BITS+12:FRAC_BITS];
          iseg_q  <= ONE;
          oseg_q  <= OSW'(mul_p >> FRAC_BITS);
          state_q <= S_PICK;
        end
        S_NEG: begin
          prod_q  <= mul_p;
          state_q <= S_NEG2;
        end
        S_NEG2: begin
          // split the skipped offset into whole pixels and a remainder
          skip_q  <= ((off >> FRAC_BITS) > 64'd8191) ? 13'd8191 : 13'(off >> FRAC_BITS);
          iseg_q  <= ONE - QW'(off[FRAC_BITS-1:0]);
          oseg_q  <= inv_eff;
          opos_q  <= '0;
          state_q <= S_PICK;
        end
        S_PICK: begin
          if (skip_q != '0) begin
            skip_q  <= skip_q - 13'd1;
            state_q <= last_q ? S_LAST : S_IDLE;
          end else if (held_v_q) begin
            state_q <= S_LOOP;
          end else begin
            held_q   <= pix_q;
            held_v_q <= 1'b1;
            state_q  <= last_q ? S_LAST : S_IDLE;
          end
        end
        S_LOOP: begin
          if (14'(opos_q) < lim_eff) state_q <= S_PV;
          else if (cur_last_q) state_q <= S_FLUSH;
          else begin
            held_q  <= pix_q;
            state_q <= last_q ? S_LAST : S_IDLE;
          end
        end
        S_PV: begin
          pv_q    <= PVW'(mul_p) + nxt_term;
          state_q <= S_AREA;
        end
        S_AREA: begin
          prod_q  <= mul_p;
          state_q <= S_ACC;
          flush_q <= 1'b0;
          if (seg_over) begin
            oseg_q <= oseg_q - OSW'(iseg_q);
            iseg_q <= ONE;
          end else begin
            iseg_q <= iseg_q - QW'(oseg_q);
            oseg_q <= inv_eff;
          end
        end
        S_ACC: begin
          // fold this step's area into the accumulator, saturating
          acc_q <= (acc_sum > 64'(ACC_MAX)) ? ACC_MAX : ACW'(acc_sum);
          if (seg_over_done_q) begin
            state_q <= cur_last_q ? S_FLUSH
                     : (last_q ? S_LAST : S_IDLE);
            if (!cur_last_q) held_q <= pix_q;
          end else begin
            state_q <= S_SC_HI;
          end
        end
        S_SC_HI: begin
          scale_q <= mul_p;
          state_q <= S_SC_LO;
        end
        S_SC_LO: begin
          scale_q <= scale_q + (mul_p >> FRAC_BITS);
          state_q <= S_EMIT;
        end
        S_EMIT: begin
          if (emit_go) begin
            opix_q  <= (sc_val > 64'd255) ? 8'd255 : sc_val[7:0];
            oidx_q  <= opos_q;
            odone_q <= flush_q;
            acc_q   <= '0;
            if (flush_q) begin
              state_q <= S_IDLE;
              held_v_q <= 1'b0;
              held_q  <= '0;
              iseg_q  <= ONE;
              oseg_q  <= '0;
              opos_q  <= '0;
              skip_q  <= '0;
              flush_q <= 1'b0;
              cur_last_q <= 1'b0;
            end else begin
              opos_q  <= opos_q + 13'd1;
              state_q <= S_LOOP;
            end
          end
        end
        S_LAST: begin
          last_q <= 1'b0;
          if (held_v_q) begin
            cur_last_q <= 1'b1;
            state_q    <= S_LOOP;
          end else begin
            state_q <= S_FLUSH;
          end
        end
        S_FLUSH: begin
          if (14'(opos_q) <= lim_eff) begin
            flush_q <= 1'b1;
            state_q <= S_SC_HI;
          end else begin
            held_v_q <= 1'b0;
            held_q   <= '0;
            iseg_q   <= ONE;
            oseg_q   <= '0;
            acc_q    <= '0;
            opos_q   <= '0;
            skip_q   <= '0;
            cur_last_q <= 1'b0;
            state_q  <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // remember whether the last area step closed the pixel without an output
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) seg_over_done_q <= 1'b0;
    else if (state_q == S_AREA) seg_over_done_q <= seg_over;
    else if (state_q == S_FLUSH) seg_over_done_q <= 1'b0;
  end

  assign out_valid_o = ov_q;
  assign pixel_out_o = opix_q;
  assign out_index_o = oidx_q;
  assign line_done_o = odone_q;

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != S_IDLE |-> in_stall_o)
    else $error("beat taken while busy");
  a_emit_on_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT && !ov_q) |=> ov_q)
    else $error("result lost");
  a_done_ends_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT && flush_q && (!ov_q || !out_stall_i)) |=>
      (state_q == S_IDLE && !held_v_q))
    else $error("line not cleared after flush");
`endif

endmodule

/* test/fant_line_resampler_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fant_line_resampler_tb: self-checking bench of the Fant line resampler
// Streams directed and random pixel lines through the block under random
// idling on both channels, predicts every resampled beat and compares them.
// ----------------------------------------------------------------------------
module fant_line_resampler_tb;
  import fant_pkg::*;

  localparam int unsigned ONE     = 32'h1_0000;
  localparam longint      ACC_TOP = (64'd1 << 28) - 1;
  localparam int          LINE_TOP = 4096;
  localparam longint      CYCLE_LIMIT = 3_000_000;

  typedef struct packed {
    logic [7:0]  pix;
    logic [12:0] idx;
    logic        done;
  } resample_beat_t;

  logic clk, rst_n;
  logic cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_data;
  logic in_valid, in_stall;
  logic [7:0] pixel_in;
  logic signed [28:0] start_pos;
  logic first_ln, last_ln;
  logic out_valid, out_stall;
  logic [7:0] pixel_out;
  logic [12:0] out_index;
  logic line_done;

  fant_line_resampler dut (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .pixel_in_i(pixel_in), .start_position_i(start_pos),
    .first_of_line_i(first_ln), .last_of_line_i(last_ln),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .pixel_out_o(pixel_out), .out_index_o(out_index), .line_done_o(line_done)
  );

  // predictor copy of the registers and line state
  longint scale_q, inv_q, limit_q;
  longint held_pix, in_seg, out_seg, acc, out_pos, skip_left;
  bit     held_ok;
  int     step_results;

  resample_beat_t expected_beats[$];
  int     error_count;
  longint cycle_count;
  bit     hold_off;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic report(input string what);
    error_count++;
    $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  function automatic longint eff_inv();
    return inv_q < ONE / 16 ? ONE / 16 : (inv_q > ONE * 16 ? ONE * 16 : inv_q);
  endfunction

  function automatic longint eff_lim();
    return limit_q > LINE_TOP ? LINE_TOP : limit_q;
  endfunction

  function automatic void clear_line();
    held_pix = 0; held_ok = 0; in_seg = ONE; out_seg = 0;
    acc = 0; out_pos = 0; skip_left = 0;
  endfunction

  // round half up, scale back to pixel range, saturate
  function automatic longint scaled_pixel();
    longint q, v;
    q = acc * (scale_q >> 16) + ((acc * (scale_q & (ONE - 1))) >> 16);
    v = (q + ONE / 2) >> 16;
    return v > 255 ? 255 : v;
  endfunction

  function automatic void push_beat(input longint val, input bit done);
    resample_beat_t b;
    if (step_results >= 36) return;
    b.pix = val[7:0]; b.idx = out_pos[12:0]; b.done = done;
    expected_beats.push_back(b);
    step_results++;
  endfunction

  function automatic void add_area(input longint pv, input longint seg);
    acc += (pv * seg + ONE / 2) >> 16;
    if (acc > ACC_TOP) acc = ACC_TOP;
  endfunction

  function automatic void blend_pixel(input longint cur, input longint nxt, input bit has_nxt);
    longint pv;
    while (out_pos < eff_lim() && step_results < 36) begin
      pv = cur * in_seg;
      if (has_nxt) pv += nxt * (ONE - in_seg);
      if (out_seg > in_seg) begin
        add_area(pv, in_seg);
        out_seg -= in_seg;
        in_seg = ONE;
        return;
      end
      add_area(pv, out_seg);
      in_seg -= out_seg;
      out_seg = eff_inv();
      push_beat(scaled_pixel(), 1'b0);
      out_pos++;
      acc = 0;
    end
  endfunction

  function automatic void open_line(input logic [28:0] s);
    longint inv, mag, off;
    inv = eff_inv();
    clear_line();
    if (s[28]) begin
      mag = 64'h2000_0000 - longint'(s);
      off = (mag * inv) >> 16;
      skip_left = (off >> 16) > 8191 ? 8191 : (off >> 16);
      in_seg = ONE - (off & (ONE - 1));
      out_seg = inv;
    end else begin
      out_pos = longint'(s[28:16]);
      out_seg = (inv * (ONE - longint'(s[15:0]))) >> 16;
    end
  endfunction

  function automatic void predict_pixel(input logic [7:0] p, input logic [28:0] s,
                                        input bit f, input bit l);
    step_results = 0;
    if (f) open_line(s);
    if (skip_left > 0) skip_left--;
    else begin
      if (held_ok) blend_pixel(held_pix, longint'(p), 1'b1);
      held_pix = longint'(p); held_ok = 1;
    end
    if (l) begin
      if (held_ok) blend_pixel(held_pix, 0, 1'b0);
      if (out_pos <= eff_lim()) push_beat(scaled_pixel(), 1'b1);
      clear_line();
    end
  endfunction

  // offer one pixel beat, hold until accepted, then predict
  task automatic send_pixel(input logic [7:0] p, input logic [28:0] s,
                            input bit f, input bit l);
    int gap;
    gap = $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1; pixel_in <= p; start_pos <= s; first_ln <= f; last_ln <= l;
    do @(posedge clk); while (in_stall);
    predict_pixel(p, s, f, l);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1; cfg_idx <= idx; cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_SIZE_FACTOR: scale_q = longint'(val);
      REG_INV_FACTOR:  inv_q   = longint'(val);
      default:         limit_q = longint'(val[12:0]);
    endcase
  endtask

  // drop the input, wait for every expected beat, allow for a silent pixel
  task automatic drain();
    in_valid <= 1'b0;
    wait (expected_beats.size() == 0);
    repeat (60) @(negedge clk);
  endtask

  task automatic set_scale(input logic [CfgDataW-1:0] sf, input logic [CfgDataW-1:0] inv,
                           input logic [CfgDataW-1:0] lim);
    drain();
    write_reg(REG_SIZE_FACTOR, sf);
    write_reg(REG_INV_FACTOR, inv);
    write_reg(REG_OUT_LIMIT, lim);
  endtask

  task automatic send_line(input int len, input logic [28:0] s);
    for (int i = 0; i < len; i++)
      send_pixel(8'($urandom_range(0, 255)), s, i == 0, i == len - 1);
  endtask

  function automatic logic [28:0] rand_start();
    case ($urandom_range(0, 3))
      0: return 29'($urandom_range(0, 3 * ONE));
      1: return -29'($urandom_range(1, 4 * ONE));
      2: return 29'($urandom);
      default: return 29'($urandom_range(0, ONE - 1));
    endcase
  endfunction

  task automatic test_directed();
    send_pixel(8'd0, 29'd0, 1'b1, 1'b0);
    send_pixel(8'd255, 29'd0, 1'b0, 1'b0);
    send_pixel(8'd255, 29'd0, 1'b0, 1'b1);
    send_pixel(8'd200, 29'h0FFF_FFFF, 1'b1, 1'b1);  // start at the limit: flush only
    send_pixel(8'd77, 29'h1000_0000, 1'b1, 1'b1);   // most negative start, all skipped
    send_pixel(8'd9, 29'd0, 1'b0, 1'b0);            // pixel with no line opened
    send_pixel(8'd170, 29'd0, 1'b0, 1'b1);
    send_pixel(8'd85, 29'h0000_8000, 1'b1, 1'b0);
    send_pixel(8'd255, 29'd0, 1'b1, 1'b0);          // line restarted, held pixel dropped
    send_pixel(8'd1, 29'd0, 1'b0, 1'b1);
    send_line(4, -29'sh0001_8000);                  // negative start skips a pixel
  endtask

  task automatic test_extreme_scales();
    set_scale(21'h1F_FFFF, 21'd0, 21'd4095);     // upscale 32x, inverse clamped
    send_line(3, 29'd0);
    set_scale(21'd4096, 21'h1F_FFFF, 21'h1FFF);  // downscale, limit clamped
    send_line(6, 29'h0000_FFFF);
    set_scale(21'h10_0000, 21'd4096, 21'd0);     // zero limit: flush only
    send_line(3, 29'd0);
    set_scale(21'h2_0000, 21'h8000, 21'd5);
    send_line(8, 29'h0002_0000);
  endtask

  // receiver stalls long while a line keeps coming, so the block backs up
  task automatic test_backpressure();
    set_scale(21'h4_0000, 21'h4000, 21'd4095);
    hold_off = 1;
    send_line(6, 29'd0);
  endtask

  task automatic test_random(input int count);
    int sent, len;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 5) == 0)
        set_scale(21'($urandom_range(4096, 1 << 20)), 21'($urandom_range(4096, 1 << 20)),
                  21'($urandom_range(0, 4096)));
      len = $urandom_range(1, 10);
      if ($urandom_range(0, 9) == 0) begin
        send_pixel(8'($urandom), 29'($urandom), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)));
        sent += 1;
      end else begin
        send_line(len, rand_start());
        sent += len;
      end
    end
  endtask

  // receiver: random wait per beat, plus the long hold-off
  initial begin
    int idle;
    out_stall = 1'b1;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      if (hold_off) begin
        out_stall <= 1'b1;
        repeat (300) @(negedge clk);
        hold_off = 0;
      end
      idle = $urandom_range(0, 4);
      if (idle > 0) begin
        out_stall <= 1'b1;
        repeat (idle) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  // check each accepted beat against the oldest expectation
  always @(posedge clk) begin
    resample_beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_beats.size() == 0) report("unexpected result beat");
      else begin
        want = expected_beats.pop_front();
        if (pixel_out !== want.pix)
          report($sformatf("pixel got %0d want %0d", pixel_out, want.pix));
        if (out_index !== want.idx)
          report($sformatf("index got %0d want %0d", out_index, want.idx));
        if (line_done !== want.done)
          report($sformatf("line_done got %0b want %0b", line_done, want.done));
      end
    end
  end

  initial begin
    cycle_count = 0; error_count = 0; hold_off = 0;
    rst_n = 1'b0; cfg_we = 1'b0; cfg_idx = '0; cfg_data = '0;
    in_valid = 1'b0; pixel_in = '0; start_pos = '0; first_ln = 0; last_ln = 0;
    scale_q = ONE; inv_q = ONE; limit_q = 4095;
    clear_line();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    test_extreme_scales();
    test_backpressure();
    set_scale(21'(ONE), 21'(ONE), 21'd4095);
    test_random(210);
    drain();
    repeat (100) @(negedge clk);
    if (error_count == 0 && expected_beats.size() == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end
endmodule
